FILE: rtl/core/signed_integer_to_ascii_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII core
// Clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_ASCII_CORE_MACROS_SVH
`define SIGNED_INTEGER_TO_ASCII_CORE_MACROS_SVH

// Property that must hold at every enabled clock edge
`define SITA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SITA_ASSERT_NEXT(label, ante, cons, msg) \
	`SITA_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/sita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_pkg
// Types, constants and helpers shared by the integer to ASCII core.
// ----------------------------------------------------------------------------
package sita_pkg;

	localparam int DIGIT_DEPTH = 32;
	localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
	localparam int COUNT_W     = DIGIT_AW + 1;

	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [3:0] DEC_MAX    = 4'd9;
	localparam logic [3:0] DEC_BASE   = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_FETCH,
		ST_DIGIT,
		ST_TERM
	} sita_state_t;

	typedef struct packed {
		logic start;
		logic div_step;
		logic load_sign;
		logic load_digit;
		logic load_term;
		logic ptr_dec;
	} sita_cmd_t;

	typedef struct packed {
		logic div_last;
		logic quot_zero;
		logic ptr_zero;
		logic out_free;
		logic neg;
	} sita_sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d > DEC_MAX) begin
			c = CHAR_A + {4'd0, d - DEC_BASE};
		end else begin
			c = CHAR_ZERO + {4'd0, d};
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/sita_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_in_if
// Input channel: value to convert and its number base.
// ----------------------------------------------------------------------------
interface sita_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic        [4:0]  radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: rtl/core/sita_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_out_if
// Output channel: one ASCII character per transfer.
// ----------------------------------------------------------------------------
interface sita_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       final_res;
	logic [5:0] length;

	modport source (output valid, output character, output final_res, output length,
		input ready);
	modport sink   (input valid, input character, input final_res, input length,
		output ready);
endinterface

FILE: rtl/core/signed_integer_to_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_core
// Converts a signed 32-bit integer to a zero-terminated ASCII string.
// ----------------------------------------------------------------------------
// din carries value and radix (clamped to 2..16); dout returns the string one
// character per transfer: optional '-', digits most significant first in
// 0-9/a-f, then a zero byte with final_res set and length = characters
// including the terminator. Other characters carry length 0.
// One item is converted at a time; din.ready is high only while idle.
// Each digit takes a full pass of the long-division unit (eight quotient
// bits per cycle over the 32-bit magnitude), then is emitted by a digit store
// read and an output register load. The terminator sits in the output register
// while the next item is accepted and divided. A stalled dout holds the
// character and freezes emission.
// Reset clears the sequencer and the output valid; the digit store needs none.
// ----------------------------------------------------------------------------
module signed_integer_to_ascii_core (
	input  logic        clk,
	input  logic        arst_n,
	sita_in_if.sink     din,
	sita_out_if.source  dout
);

	sita_pkg::sita_cmd_t cmd;
	sita_pkg::sita_sts_t sts;

	sita_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	sita_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (din.value),
		.radix     (din.radix),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.character (dout.character),
		.final_res (dout.final_res),
		.length    (dout.length)
	);

endmodule

FILE: rtl/core/sita_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_ctrl
// Sequencer: accept, divide digit by digit, then emit sign, digits, terminator.
// ----------------------------------------------------------------------------
module sita_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output sita_pkg::sita_cmd_t cmd,
	input  sita_pkg::sita_sts_t sts
);

	sita_pkg::sita_state_t state_q;
	sita_pkg::sita_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sita_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sita_pkg::ST_IDLE: begin
				if (in_valid) state_d = sita_pkg::ST_DIVIDE;
			end
			sita_pkg::ST_DIVIDE: begin
				if (sts.div_last && sts.quot_zero) begin
					state_d = sts.neg ? sita_pkg::ST_SIGN : sita_pkg::ST_FETCH;
				end
			end
			sita_pkg::ST_SIGN: begin
				if (sts.out_free) state_d = sita_pkg::ST_FETCH;
			end
			sita_pkg::ST_FETCH: begin
				state_d = sita_pkg::ST_DIGIT;
			end
			sita_pkg::ST_DIGIT: begin
				if (sts.out_free) begin
					state_d = sts.ptr_zero ? sita_pkg::ST_TERM : sita_pkg::ST_FETCH;
				end
			end
			sita_pkg::ST_TERM: begin
				if (sts.out_free) state_d = sita_pkg::ST_IDLE;
			end
			default: begin
				state_d = sita_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			sita_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			sita_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			sita_pkg::ST_SIGN: begin
				cmd.load_sign = sts.out_free;
			end
			sita_pkg::ST_FETCH: begin
				cmd = '0;
			end
			sita_pkg::ST_DIGIT: begin
				cmd.load_digit = sts.out_free;
				cmd.ptr_dec    = sts.out_free && !sts.ptr_zero;
			end
			sita_pkg::ST_TERM: begin
				cmd.load_term = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/sita_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_dp
// Datapath: byte-wide long division by the base, digit store, output register.
// ----------------------------------------------------------------------------
module sita_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [31:0]  value,
	input  logic        [4:0]   radix,
	input  sita_pkg::sita_cmd_t cmd,
	output sita_pkg::sita_sts_t sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic        [7:0]   character,
	output logic                final_res,
	output logic        [5:0]   length
);

	logic [31:0]                    work_q;
	logic [3:0]                     rem_q;
	logic [4:0]                     radix_q;
	logic                           neg_q;
	logic [1:0]                     step_q;
	logic [sita_pkg::COUNT_W-1:0]   count_q;
	logic [sita_pkg::DIGIT_AW-1:0]  ptr_q;
	logic [3:0]                     mem [sita_pkg::DIGIT_DEPTH];
	logic [3:0]                     rd_data_q;
	logic                           out_valid_q;
	logic [7:0]                     char_q;
	logic                           final_q;
	logic [5:0]                     length_q;

	logic [31:0] value_u;
	logic [31:0] mag;
	logic [4:0]  radix_c;
	logic [31:0] div_work;
	logic [3:0]  div_rem;
	logic        div_last;
	logic        out_free;

	assign value_u = $unsigned(value);
	assign mag     = value_u[31] ? (32'd0 - value_u) : value_u;

	always_comb begin
		if (radix < sita_pkg::RADIX_MIN) begin
			radix_c = sita_pkg::RADIX_MIN;
		end else if (radix > sita_pkg::RADIX_MAX) begin
			radix_c = sita_pkg::RADIX_MAX;
		end else begin
			radix_c = radix;
		end
	end

	// Eight quotient bits per cycle; the partial remainder stays below the base.
	always_comb begin
		logic [7:0] top;
		logic [7:0] qbits;
		logic [4:0] t;
		logic [3:0] r;
		top   = work_q[31:24];
		qbits = '0;
		r     = rem_q;
		for (int i = 0; i < 8; i++) begin
			t = {r, top[7-i]};
			if (t >= radix_q) begin
				t          = t - radix_q;
				qbits[7-i] = 1'b1;
			end
			r = t[3:0];
		end
		div_rem  = r;
		div_work = {work_q[23:0], qbits};
	end

	assign div_last = (step_q == 2'd3);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts.div_last  = div_last;
		sts.quot_zero = (div_work == '0);
		sts.ptr_zero  = (ptr_q == '0);
		sts.out_free  = out_free;
		sts.neg       = neg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				step_q  <= '0;
				count_q <= '0;
				neg_q   <= value_u[31];
			end else if (cmd.div_step) begin
				step_q <= step_q + 2'd1;
				if (div_last) begin
					count_q <= count_q + 1'b1;
					ptr_q   <= count_q[sita_pkg::DIGIT_AW-1:0];
				end
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			work_q  <= mag;
			rem_q   <= '0;
			radix_q <= radix_c;
		end else if (cmd.div_step) begin
			work_q <= div_work;
			rem_q  <= div_last ? 4'd0 : div_rem;
		end
	end

	// Digit store: one write port during division, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.div_step && div_last) begin
			mem[count_q[sita_pkg::DIGIT_AW-1:0]] <= div_rem;
		end
		rd_data_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_sign || cmd.load_digit || cmd.load_term) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sign) begin
			char_q   <= sita_pkg::CHAR_MINUS;
			final_q  <= 1'b0;
			length_q <= '0;
		end else if (cmd.load_digit) begin
			char_q   <= sita_pkg::digit_char(rd_data_q);
			final_q  <= 1'b0;
			length_q <= '0;
		end else if (cmd.load_term) begin
			char_q   <= sita_pkg::CHAR_NUL;
			final_q  <= 1'b1;
			length_q <= count_q + {5'd0, neg_q} + 6'd1;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign final_res = final_q;
	assign length    = length_q;

endmodule

FILE: rtl/core/sita_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sita_checker
// Port-level checks on the integer to ASCII core, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_integer_to_ascii_core_macros.svh"

module sita_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_final,
	input logic [5:0] out_len
);

	// A conversion in progress blocks the input.
	`SITA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

	`SITA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_final) && $stable(out_len), "stalled output changed")

	`SITA_ASSERT(a_term_format, (out_valid && out_final) |-> (out_char == sita_pkg::CHAR_NUL && out_len >= 6'd2 && out_len <= 6'd34), "bad terminator item")

	`SITA_ASSERT(a_body_format, (out_valid && !out_final) |-> (out_len == 6'd0 && out_char != sita_pkg::CHAR_NUL), "bad string character")

endmodule

bind signed_integer_to_ascii_core sita_checker u_sita_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_char  (dout.character),
	.out_final (dout.final_res),
	.out_len   (dout.length)
);

FILE: test/signed_integer_to_ascii_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_core_tb
// Feeds values and bases into the converter and checks every character it
// returns. Checks come from a table of corner cases followed by random
// conversions, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module signed_integer_to_ascii_core_tb;

	localparam int RANDOM_ITEMS = 340;
	localparam int MAX_GAP      = 11;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 250;
	localparam int REPORT_MAX   = 10;

	localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789abcdef";

	typedef struct packed {
		logic [7:0] character;
		logic       final_res;
		logic [5:0] length;
	} glyph_t;

	logic clk = 1'b0;
	logic arst_n;

	sita_in_if  din();
	sita_out_if dout();

	signed_integer_to_ascii_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	glyph_t             pending_chars[$];
	logic signed [31:0] case_value[$];
	logic [4:0]         case_radix[$];
	string              case_text[$];
	int                 mismatches = 0;
	int                 received   = 0;

	always #5 clk = ~clk;

	function automatic void push_char(input logic [7:0] c, input logic fin,
		input logic [5:0] len);
		glyph_t g;
		g.character = c;
		g.final_res = fin;
		g.length    = len;
		pending_chars.push_back(g);
	endfunction

	// Queue the characters of one conversion: sign, digits MSB first, NUL.
	function automatic void predict_string(input logic signed [31:0] v,
		input logic [4:0] r);
		logic [4:0]  base;
		logic [31:0] mag;
		logic [3:0]  rem [32];
		logic        neg;
		int          n;
		base = (r < sita_pkg::RADIX_MIN) ? sita_pkg::RADIX_MIN :
			((r > sita_pkg::RADIX_MAX) ? sita_pkg::RADIX_MAX : r);
		neg  = v[31];
		mag  = neg ? (32'd0 - 32'(v)) : 32'(v);
		n    = 0;
		do begin
			rem[n] = 4'(mag % 32'(base));
			mag    = mag / 32'(base);
			n++;
		end while (mag != 0);
		if (neg) begin
			push_char(sita_pkg::CHAR_MINUS, 1'b0, 6'd0);
		end
		for (int k = n - 1; k >= 0; k--) begin
			push_char(DIGIT_GLYPHS[8*(15 - int'(rem[k])) +: 8], 1'b0, 6'd0);
		end
		push_char(sita_pkg::CHAR_NUL, 1'b1, 6'(n + int'(neg) + 1));
	endfunction

	function automatic void expect_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i], 1'b0, 6'd0);
		end
		push_char(sita_pkg::CHAR_NUL, 1'b1, 6'(s.len() + 1));
	endfunction

	// Empty text: expectation comes from predict_string.
	function automatic void add_case(input logic signed [31:0] v, input logic [4:0] r,
		input string s);
		case_value.push_back(v);
		case_radix.push_back(r);
		case_text.push_back(s);
	endfunction

	function automatic logic signed [31:0] random_value();
		logic [31:0] bits;
		case ($urandom_range(0, 5))
			0, 1: bits = $urandom();
			2: bits = 32'($urandom_range(0, 2000)) - 32'd1000;
			3: begin
				if ($urandom_range(0, 1) == 1)
					bits = 32'h8000_0000 + 32'($urandom_range(0, 15));
				else
					bits = 32'h7fff_ffff - 32'($urandom_range(0, 15));
			end
			default: begin
				bits = $urandom() >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					bits = 32'd0 - bits;
			end
		endcase
		return bits;
	endfunction

	function automatic logic [4:0] random_radix();
		case ($urandom_range(0, 9))
			0: return 5'($urandom_range(0, 1));
			1: return 5'($urandom_range(17, 31));
			default: return 5'($urandom_range(2, 16));
		endcase
	endfunction

	// Hold valid after the transfer so back-to-back items need not drop and raise it again.
	task automatic offer(input logic signed [31:0] v, input logic [4:0] r, input int gap);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.value <= v;
		din.radix <= r;
		do @(posedge clk); while (din.ready !== 1'b1);
	endtask

	task automatic wait_all_returned();
		din.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] v;
		logic [4:0]         r;
		int                 gap;
		arst_n    <= 1'b0;
		din.valid <= 1'b0;
		din.value <= '0;
		din.radix <= '0;

		add_case(32'sd0, 5'd10, "0");
		add_case(32'sd0, 5'd2, "0");
		add_case(32'sh8000_0000, 5'd2,
			{"-1", "0000000000", "0000000000", "0000000000", "0"});
		add_case(32'sh8000_0000, 5'd16, "-80000000");
		add_case(32'sh8000_0000, 5'd10, "-2147483648");
		add_case(32'sh7fff_ffff, 5'd10, "2147483647");
		add_case(32'sh7fff_ffff, 5'd16, "7fffffff");
		add_case(32'sh7fff_ffff, 5'd2, "");
		add_case(-32'sd1, 5'd10, "-1");
		add_case(32'sd1, 5'd2, "1");
		add_case(32'sd255, 5'd16, "ff");
		add_case(32'sh00ab_cdef, 5'd16, "abcdef");
		add_case(32'sd1234567890, 5'd10, "1234567890");
		add_case(32'sd5, 5'd0, "101");
		add_case(32'sd6, 5'd1, "110");
		add_case(32'sd255, 5'd17, "ff");
		add_case(-32'sd255, 5'd31, "-ff");
		add_case(32'sd0, 5'd31, "0");
		add_case(32'sh8000_0000, 5'd31, "-80000000");
		add_case(32'sd100, 5'd3, "");
		add_case(-32'sd12345, 5'd7, "");
		add_case(32'sh00fe_dcba, 5'd12, "");
		add_case(32'sd999, 5'd9, "");
		add_case(32'sh7fff_ffff, 5'd0, "");

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (case_value[i]) begin
			offer(case_value[i], case_radix[i], $urandom_range(0, MAX_GAP));
			if (case_text[i] == "")
				predict_string(case_value[i], case_radix[i]);
			else
				expect_text(case_text[i]);
		end
		wait_all_returned();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			v   = random_value();
			r   = random_radix();
			gap = ((i / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
			offer(v, r, gap);
			predict_string(v, r);
			if (i == RANDOM_ITEMS / 2)
				wait_all_returned();
		end
		wait_all_returned();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		int     stall;
		glyph_t want;
		dout.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = ((received / 200) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
			// long hold-off: fill the core so din stalls
			if (received == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				dout.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout.ready <= 1'b1;
			do @(posedge clk); while (dout.valid !== 1'b1);
			received++;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected transfer: char %h final %b length %0d",
						dout.character, dout.final_res, dout.length);
			end else begin
				want = pending_chars.pop_front();
				if (dout.character !== want.character || dout.final_res !== want.final_res
					|| dout.length !== want.length) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected char %h final %b length %0d, got %h %b %0d",
							want.character, want.final_res, want.length,
							dout.character, dout.final_res, dout.length);
				end
			end
		end
	end

	initial begin
		#12_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sita_pkg.sv
rtl/core/sita_in_if.sv
rtl/core/sita_out_if.sv
rtl/core/sita_ctrl.sv
rtl/core/sita_dp.sv
rtl/core/signed_integer_to_ascii_core.sv
rtl/core/sita_checker.sv
test/signed_integer_to_ascii_core_tb.sv
